// File: rtl/core/ttlc_pkg.sv
// Package for the TTL-keyed cache tag store: request and response beat types,
// operation and status codes, fixed field widths. No dependencies.
package ttlc_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned TTL_W    = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned TALLY_W  = 32;
  localparam int unsigned DATA_W   = COUNT_W + HANDLE_W;

  localparam logic [TTL_W-1:0] TTL_RESET = 8'd5;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef enum logic {
    STATUS_OK        = 1'b0,
    STATUS_BAD_PARAM = 1'b1
  } status_e;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [KEY_W-1:0]   pid;
    logic [TIME_W-1:0]         now_seconds;
    logic [COUNT_W-1:0]        map_count;
    logic [HANDLE_W-1:0]       map_handle;
  } req_t;

  typedef struct packed {
    logic                      status;
    logic                      hit;
    logic [SLOT_W-1:0]         slot;
    logic [COUNT_W-1:0]        found_count;
    logic [HANDLE_W-1:0]       found_handle;
    logic [TALLY_W-1:0]        hit_count;
    logic [TALLY_W-1:0]        miss_count;
  } rsp_t;

  typedef logic [TTL_W-1:0] cfg_t;

endpackage

// File: rtl/core/ttlc_chan_if.sv
// Valid/ready channel carrying one payload beat of a chosen type.
// Used for request, response and configuration channels; no dependencies.
interface ttlc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/ttlc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module ttlc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/ttlc_victim_sel.sv
// Fill slot selection: first invalid slot, else the oldest stamp through a
// compare tree, lowest index on ties. Depends on ttlc_pkg.
module ttlc_victim_sel #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic [ENTRIES-1:0]               valid_i,
  input  logic [ttlc_pkg::TIME_W-1:0]      age_i [ENTRIES],
  output logic [$clog2(ENTRIES)-1:0]       victim_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned LEAVES = 1 << IDX_W;
  localparam int unsigned NODES = 2 * LEAVES - 1;

  logic                              node_v   [NODES];
  logic signed [ttlc_pkg::TIME_W-1:0] node_age [NODES];
  logic [IDX_W-1:0]                  node_idx [NODES];

  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < ENTRIES) begin : g_used
      assign node_v[LEAVES-1+i]   = 1'b1;
      assign node_age[LEAVES-1+i] = $signed(age_i[i]);
    end else begin : g_pad
      assign node_v[LEAVES-1+i]   = 1'b0;
      assign node_age[LEAVES-1+i] = '0;
    end
    assign node_idx[LEAVES-1+i] = IDX_W'(i);
  end

  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    logic take_right;
    assign take_right = node_v[2*k+2] &&
                        (!node_v[2*k+1] || (node_age[2*k+2] > node_age[2*k+1]));
    assign node_v[k]   = node_v[2*k+1] | node_v[2*k+2];
    assign node_age[k] = take_right ? node_age[2*k+2] : node_age[2*k+1];
    assign node_idx[k] = take_right ? node_idx[2*k+2] : node_idx[2*k+1];
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_i[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign victim_o = free_found ? free_idx : node_idx[0];

endmodule

// File: rtl/core/ttl_keyed_cache_tag_store.sv
// Fully associative tag store keyed by process id, with time-to-live expiry.
// Depends on ttlc_pkg, ttlc_chan_if, ttlc_ram and ttlc_victim_sel.
//
// Channels: req_i takes one operation per beat (lookup, fill, flush); rsp_o
// returns exactly one response beat per request, in order; cfg_i writes the
// TTL in seconds and is always ready.
// Pipeline: an accepted request waits in the input register and is processed
// into the response register once that register is empty or being taken.
// Throughput: one request per cycle unless rsp_o stalls. Keys and ages of all
// slots are compared in parallel, the fill slot comes from a log2(ENTRIES)-deep
// compare tree, all between the input register and the response register; the
// slot state is updated on the same edge, so the next request sees it.
// Stored count and handle live in a small RAM read at the hit slot; its
// registered read lines up with the response register.
// Reset: all slots invalid, both tallies zero, TTL 5 seconds. No clearing
// pass is needed.
// Stall: while rsp_o is not taken the response holds; one more request is
// held in the input register, after which req_i.ready drops.
module ttl_keyed_cache_tag_store #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ttlc_chan_if.sink         req_i,
  ttlc_chan_if.source       rsp_o,
  ttlc_chan_if.sink         cfg_i
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  logic                            s1_valid_q;
  ttlc_pkg::req_t                  s1_q;
  logic                            rsp_valid_q;
  ttlc_pkg::rsp_t                  rsp_q;
  ttlc_pkg::rsp_t                  rsp_d;
  logic [ttlc_pkg::TTL_W-1:0]      ttl_q;
  logic [ENTRIES-1:0]              valid_q;
  logic [ENTRIES-1:0]              valid_d;
  logic [ttlc_pkg::KEY_W-1:0]      key_q [ENTRIES];
  logic [ttlc_pkg::TIME_W-1:0]     stamp_q [ENTRIES];
  logic [ttlc_pkg::TALLY_W-1:0]    hits_q;
  logic [ttlc_pkg::TALLY_W-1:0]    hits_d;
  logic [ttlc_pkg::TALLY_W-1:0]    misses_q;
  logic [ttlc_pkg::TALLY_W-1:0]    misses_d;

  logic                            advance;
  logic                            bad_key;
  logic                            is_lookup;
  logic                            is_fill;
  logic                            is_flush;
  logic                            do_fill;
  logic [ttlc_pkg::TIME_W-1:0]     age [ENTRIES];
  logic [ENTRIES-1:0]              key_match;
  logic [ENTRIES-1:0]              fresh_match;
  logic                            hit_found;
  logic [IDX_W-1:0]                hit_idx;
  logic [IDX_W-1:0]                victim_idx;
  logic [ttlc_pkg::DATA_W-1:0]     ram_rdata;

  assign advance     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= req_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= ttlc_pkg::TTL_RESET;
    end else if (cfg_i.valid) begin
      ttl_q <= cfg_i.payload;
    end
  end

  assign bad_key   = s1_q.pid[ttlc_pkg::KEY_W-1] || (s1_q.pid == '0);
  assign is_lookup = (s1_q.op == ttlc_pkg::OP_LOOKUP);
  assign is_fill   = (s1_q.op == ttlc_pkg::OP_FILL);
  assign is_flush  = (s1_q.op == ttlc_pkg::OP_FLUSH);
  assign do_fill   = advance && is_fill && !bad_key;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cmp
    assign age[i]         = s1_q.now_seconds - stamp_q[i];
    assign key_match[i]   = valid_q[i] && (key_q[i] == s1_q.pid);
    assign fresh_match[i] = key_match[i] &&
                            ($signed(age[i]) < $signed({24'd0, ttl_q}));
  end

  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (fresh_match[i]) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
    end
  end

  ttlc_victim_sel #(
    .ENTRIES (ENTRIES)
  ) u_victim (
    .valid_i  (valid_q),
    .age_i    (age),
    .victim_o (victim_idx)
  );

  ttlc_ram #(
    .WIDTH (ttlc_pkg::DATA_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (do_fill),
    .waddr_i (victim_idx),
    .wdata_i ({s1_q.map_count, s1_q.map_handle}),
    .re_i    (advance && is_lookup),
    .raddr_i (hit_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    valid_d  = valid_q;
    hits_d   = hits_q;
    misses_d = misses_q;
    rsp_d    = '0;
    rsp_d.status = ttlc_pkg::STATUS_OK;
    case (ttlc_pkg::op_e'(s1_q.op))
      ttlc_pkg::OP_LOOKUP: begin
        if (bad_key) begin
          rsp_d.status = ttlc_pkg::STATUS_BAD_PARAM;
        end else if (hit_found) begin
          hits_d     = hits_q + 1'b1;
          rsp_d.hit  = 1'b1;
          rsp_d.slot = ttlc_pkg::SLOT_W'(hit_idx);
        end else begin
          misses_d = misses_q + 1'b1;
        end
      end
      ttlc_pkg::OP_FILL: begin
        if (bad_key) begin
          rsp_d.status = ttlc_pkg::STATUS_BAD_PARAM;
        end else begin
          valid_d[victim_idx] = 1'b1;
          rsp_d.slot = ttlc_pkg::SLOT_W'(victim_idx);
        end
      end
      ttlc_pkg::OP_FLUSH: begin
        valid_d = bad_key ? '0 : (valid_q & ~key_match);
      end
      default: begin
      end
    endcase
    rsp_d.hit_count  = hits_d;
    rsp_d.miss_count = misses_d;
  end

  // slot state and tallies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
    end else if (advance) begin
      valid_q  <= valid_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_fill) begin
      key_q[victim_idx]   <= s1_q.pid;
      stamp_q[victim_idx] <= s1_q.now_seconds;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;

  always_comb begin
    rsp_o.payload = rsp_q;
    if (rsp_q.hit) begin
      rsp_o.payload.found_count  = ram_rdata[ttlc_pkg::DATA_W-1:ttlc_pkg::HANDLE_W];
      rsp_o.payload.found_handle = ram_rdata[ttlc_pkg::HANDLE_W-1:0];
    end
  end

  a_flush_all_clears: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && is_flush && bad_key) |=> (valid_q == '0)
  ) else $error("flush of all slots left a slot valid");

  a_hit_bumps_tally: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && is_lookup && !bad_key && hit_found) |=>
      (hits_q == $past(hits_q) + 1'b1) && $stable(misses_q)
  ) else $error("lookup hit did not bump the hit tally alone");

  a_fill_sets_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    do_fill |=> valid_q[$past(victim_idx)]
  ) else $error("filled slot not valid");

  a_stall_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && rsp_valid_q && !rsp_o.ready) |-> !req_i.ready
  ) else $error("request taken while both registers are full");

endmodule
